FILE: rtl/histogram_equalization_lut_defines.svh
// Assertion macros shared by the histogram equalization table generator.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HISTOGRAM_EQUALIZATION_LUT_DEFINES_SVH
`define HISTOGRAM_EQUALIZATION_LUT_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define HEL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define HEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hel_pkg.sv
// Package for the histogram equalization table generator.
// Holds widths, payload structs, queue entry and back-end state types; no dependencies.
package hel_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int CNT_W       = COUNT_WIDTH + 1;
    localparam int LEVEL_W     = 8;
    localparam int LEVEL_SCALE = 2 * 255;
    // 510 * num + den stays below 2^(CNT_W + 9); one spare bit on top
    localparam int REM_W       = CNT_W + 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);
    localparam logic [CNT_W-1:0]   PC_RESET  = CNT_W'(1);

    typedef enum logic [0:0] {
        REG_PIXEL_COUNT = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic             last_bin;
    } t_bin_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] lut_value;
        logic               last_entry;
        logic               degenerate;
    } t_lut_out;

    typedef struct packed {
        logic [CNT_W-1:0] cum_sum;
        logic [CNT_W-1:0] first_count;
        logic             seen;
        logic             last;
    } t_hel_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_hel_qstat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_CHECK,
        BK_ITER,
        BK_DONE
    } t_back_state;

endpackage

FILE: rtl/hel_front.sv
// Front end: accepts bin beats, keeps the running sum and the first nonzero count.
// Depends on hel_pkg; pushes one entry per beat into hel_queue.
module hel_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hel_pkg::t_bin_in     i_in_data,
    input  hel_pkg::t_hel_qstat  i_qstat,
    output logic                 o_push,
    output hel_pkg::t_hel_entry  o_entry
);
    import hel_pkg::*;

    logic [CNT_W-1:0] r_cum, n_cum;
    logic [CNT_W-1:0] r_first, n_first;
    logic             r_seen, n_seen;
    logic [CNT_W:0]   w_sum;
    logic             w_nonzero;

    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && o_in_ready;
    assign w_nonzero  = (i_in_data.bin_count != '0);
    assign w_sum      = {1'b0, r_cum} + {1'b0, i_in_data.bin_count};

    always_comb begin
        n_seen  = r_seen || w_nonzero;
        n_first = (!r_seen && w_nonzero) ? i_in_data.bin_count : r_first;
        // saturate the running sum at all ones
        n_cum   = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];
    end

    always_comb begin
        o_entry.cum_sum     = n_cum;
        o_entry.first_count = n_first;
        o_entry.seen        = n_seen;
        o_entry.last        = i_in_data.last_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cum   <= '0;
            r_first <= '0;
            r_seen  <= 1'b0;
        end else if (o_push) begin
            if (i_in_data.last_bin) begin
                r_cum   <= '0;
                r_first <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_cum   <= n_cum;
                r_first <= n_first;
                r_seen  <= n_seen;
            end
        end
    end

endmodule

FILE: rtl/hel_queue.sv
// Short FIFO of classified bins between front and back end.
// Depends on hel_pkg; DEPTH comes from the top level (2 and up).
module hel_queue #(
    parameter int DEPTH = hel_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hel_pkg::t_hel_entry  i_entry,
    input  logic                 i_pop,
    output hel_pkg::t_hel_entry  o_entry,
    output hel_pkg::t_hel_qstat  o_qstat
);
    import hel_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_hel_entry        r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              w_push, w_pop;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_QW'(DEPTH));
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_entry       = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

FILE: rtl/hel_back.sv
// Back end: scales each queued bin to a level with a restoring divider, 8 quotient bits.
// Depends on hel_pkg; holds the result beat in an output register.
module hel_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hel_pkg::t_hel_entry           i_entry,
    input  hel_pkg::t_hel_qstat           i_qstat,
    output logic                          o_pop,
    input  logic [hel_pkg::CNT_W-1:0]     i_pixel_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hel_pkg::t_lut_out             o_out_data
);
    import hel_pkg::*;

    t_back_state         r_state, n_state;
    logic [CNT_W-1:0]    r_num, n_num;
    logic [CNT_W-1:0]    r_den, n_den;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [REM_W-1:0]    r_dsr, n_dsr;
    logic [LEVEL_W-1:0]  r_q, n_q;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_skip, n_skip;
    logic                r_sat, n_sat;
    logic                r_degen, n_degen;
    logic                r_last, n_last;
    t_lut_out            r_out, n_out;
    logic                r_out_valid, n_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_skip  <= n_skip;
        r_sat   <= n_sat;
        r_degen <= n_degen;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_skip      = r_skip;
        n_sat       = r_sat;
        n_degen     = r_degen;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_num   = i_entry.cum_sum - i_entry.first_count;
                    n_den   = i_pixel_count - i_entry.first_count;
                    n_degen = !i_entry.seen || (i_pixel_count == i_entry.first_count);
                    // pixel count below min gives a negative ratio: level 0
                    n_skip  = n_degen || (i_pixel_count < i_entry.first_count);
                    n_last  = i_entry.last;
                    n_sat   = 1'b0;
                    n_q     = '0;
                    n_state = BK_PREP;
                end
            end
            BK_PREP: begin
                // dividend 2*255*num + den, divisor 2*den aligned to quotient bit 7
                n_rem = REM_W'(r_num) * REM_W'(LEVEL_SCALE) + REM_W'(r_den);
                n_dsr = REM_W'(r_den) << LEVEL_W;
                n_state = r_skip ? BK_DONE : BK_CHECK;
            end
            BK_CHECK: begin
                // quotient of 256 or more saturates
                n_sat   = (r_rem >= (r_dsr << 1));
                n_cnt   = 3'd7;
                n_state = n_sat ? BK_DONE : BK_ITER;
            end
            BK_ITER: begin
                if (r_rem >= r_dsr) begin
                    n_rem = r_rem - r_dsr;
                    n_q   = {r_q[LEVEL_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[LEVEL_W-2:0], 1'b0};
                end
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.lut_value  = r_sat ? LEVEL_MAX : (r_skip ? '0 : r_q);
                    n_out.last_entry = r_last;
                    n_out.degenerate = r_degen;
                    n_out_valid      = 1'b1;
                    n_state          = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/histogram_equalization_lut.sv
// Channel   Handshake                 Payload
// bins in   i_in_valid / o_in_ready   i_in_data  (bin_count, last_bin)
// table out o_out_valid / i_out_ready o_out_data (lut_value, last_entry, degenerate)
// config    APB psel/penable/pwrite   pixel_count at byte address 0
//
// A bin passes the back end in order: setup, scale, range check, eight divider
// steps, output load; the restoring divider sets the rate, one bin at a time.
// Saturated bins skip the divider steps, degenerate or clamped bins also the check.
// The front takes one beat per cycle until the QUEUE_DEPTH-entry queue fills.
// A stalled output holds the back end in its final state; the queue keeps filling.
// Reset is synchronous, active low; pixel_count resets to 1, run state to zero.
// Top level of the histogram equalization table generator.
// Depends on hel_pkg, hel_front, hel_queue, hel_back and the defines header.
`include "histogram_equalization_lut_defines.svh"

module histogram_equalization_lut #(
    parameter int QUEUE_DEPTH = hel_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hel_pkg::t_bin_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hel_pkg::t_lut_out             o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hel_pkg::PADDR_W-1:0]   paddr,
    input  logic [hel_pkg::PDATA_W-1:0]   pwdata,
    output logic [hel_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import hel_pkg::*;

    logic [CNT_W-1:0] r_pixel_count;
    logic             w_cfg_wr;
    logic             w_reg_hit;
    logic             w_push, w_pop;
    t_hel_entry       w_push_entry, w_head_entry;
    t_hel_qstat       w_qstat;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[REG_IDX_LSB] == REG_PIXEL_COUNT);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_hit;
    assign prdata    = w_reg_hit ? PDATA_W'(r_pixel_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= PC_RESET;
        end else if (w_cfg_wr) begin
            r_pixel_count <= pwdata[CNT_W-1:0];
        end
    end

    hel_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    hel_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_qstat (w_qstat)
    );

    hel_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_head_entry),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .i_pixel_count (r_pixel_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    `HEL_ASSERT(a_degen_level_zero, o_out_valid && o_out_data.degenerate, o_out_data.lut_value == '0, "degenerate beat with nonzero level")
    `HEL_ASSERT(a_queue_status, 1'b1, !(w_qstat.empty && w_qstat.full), "queue empty and full at once")
    `HEL_ASSERT(a_pop_nonempty, w_pop, !w_qstat.empty, "back end popped an empty queue")
    `HEL_ASSERT_NEXT(a_pop_frees, w_pop && !w_push, !w_qstat.full, "queue still full after a pop")

endmodule

FILE: tb/sv/histogram_equalization_lut_tb.sv
`timescale 1ns / 1ps
// Testbench for histogram_equalization_lut: drives bin beats and APB register writes,
// predicts every table entry in a scoreboard class and checks the output beats in order.
// Depends on hel_pkg and the histogram_equalization_lut RTL.

module histogram_equalization_lut_tb;
    import hel_pkg::*;

    localparam int               RANDOM_BINS = 1550;
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

    // Running equalization model plus the queue of entries still owed by the block.
    class lut_scoreboard;
        logic [CNT_W-1:0] pixel_count;
        logic [CNT_W-1:0] run_sum;
        logic [CNT_W-1:0] first_count;
        logic             seen;
        t_lut_out         pending[$];
        int               mismatches;
        int               entries_checked;
        int               degenerate_entries;
        int               saturated_entries;

        function new();
            pixel_count        = PC_RESET;
            run_sum            = '0;
            first_count        = '0;
            seen               = 1'b0;
            mismatches         = 0;
            entries_checked    = 0;
            degenerate_entries = 0;
            saturated_entries  = 0;
        endfunction

        function void note_bin(t_bin_in b);
            logic [CNT_W:0] sum;
            logic [63:0]    num;
            logic [63:0]    den;
            logic [63:0]    quot;
            t_lut_out       entry;
            if (!seen && b.bin_count != '0) begin
                seen        = 1'b1;
                first_count = b.bin_count;
            end
            // cumulative sum saturates instead of wrapping
            sum     = {1'b0, run_sum} + {1'b0, b.bin_count};
            run_sum = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];

            entry.lut_value  = '0;
            entry.last_entry = b.last_bin;
            entry.degenerate = 1'b0;
            if (!seen || pixel_count == first_count) begin
                entry.degenerate = 1'b1;
            end else if (pixel_count > first_count) begin
                num  = 64'(run_sum - first_count);
                den  = 64'(pixel_count - first_count);
                // round half up: (2*num*255 + den) / (2*den)
                quot = (num * LEVEL_SCALE + den) / (den * 2);
                entry.lut_value = (quot > 64'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];
            end
            // pixel_count below min leaves the entry clamped at zero
            pending.push_back(entry);

            if (b.last_bin) begin
                run_sum     = '0;
                first_count = '0;
                seen        = 1'b0;
            end
        endfunction

        function void check_entry(t_lut_out got);
            t_lut_out want;
            if (pending.size() == 0) begin
                $error("output beat with no bin waiting: lut_value %0d", got.lut_value);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            entries_checked++;
            if (want.degenerate) degenerate_entries++;
            if (want.lut_value == LEVEL_MAX) saturated_entries++;
            if (got.lut_value !== want.lut_value) begin
                $error("lut_value: expected %0d, got %0d", want.lut_value, got.lut_value);
                mismatches++;
            end
            if (got.last_entry !== want.last_entry) begin
                $error("last_entry: expected %0b, got %0b", want.last_entry, got.last_entry);
                mismatches++;
            end
            if (got.degenerate !== want.degenerate) begin
                $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_bin_in              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_lut_out             o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    lut_scoreboard sb = new();
    int            bins_sent    = 0;
    int            tables_sent  = 0;
    int            settings     = 0;
    bit            calm         = 1'b0;
    bit            hold_request = 1'b0;

    histogram_equalization_lut dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_bin(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_entry(o_out_data);
        end
    end

    // Output side: random backpressure, one long hold-off on request.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic set_pixel_count(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_PIXEL_COUNT) << REG_IDX_LSB;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.pixel_count = value;
        settings++;
        // read back: new setup phase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== value) begin
            $error("pixel_count readback: expected %0d, got %0d", value, prdata[CNT_W-1:0]);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_bin(input logic [CNT_W-1:0] count, input logic last);
        while (!calm && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{bin_count: count, last_bin: last};
        do @(posedge i_clk); while (!o_in_ready);
        bins_sent++;
    endtask

    // Hold off the register port until every bin has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.entries_checked < bins_sent) @(posedge i_clk);
    endtask

    // Mostly histograms that sum to pc; the rest are noise frames with arbitrary counts.
    task automatic send_frame(input logic [CNT_W-1:0] pc);
        int               len;
        int               lead;
        bit               tidy;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] bin;
        tidy = ($urandom_range(99) < 80);
        len  = ($urandom_range(29) == 0) ? 256 : $urandom_range(1, 24);
        lead = ($urandom_range(1) == 1) ? $urandom_range(0, (len > 3) ? 3 : len - 1) : 0;
        left = pc;
        for (int i = 0; i < len; i++) begin
            if (!tidy) begin
                case ($urandom_range(3))
                    0:       bin = '0;
                    1:       bin = CNT_W'($urandom_range(0, 1000));
                    default: bin = CNT_W'($urandom);
                endcase
            end else begin
                if (i < lead) begin
                    bin = '0;
                end else if (i == len - 1) begin
                    bin = left;
                end else if ($urandom_range(3) == 0) begin
                    bin = '0;
                end else begin
                    bin = CNT_W'($urandom_range(0, int'(left)));
                end
                left = left - bin;
            end
            send_bin(bin, i == len - 1);
        end
        tables_sent++;
    endtask

    initial begin
        int               phase;
        int               phase_end;
        int               target;
        int               waited;
        logic [CNT_W-1:0] pc;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_pixel_count(25'd100);
        // leading empty bins, then an ordinary table
        send_bin(25'd0, 1'b0);
        send_bin(25'd0, 1'b0);
        send_bin(25'd10, 1'b0);
        send_bin(25'd40, 1'b0);
        send_bin(25'd50, 1'b1);
        // min equals pixel_count: zero divisor
        send_bin(25'd100, 1'b1);
        // min above pixel_count: clamp to zero
        send_bin(25'd200, 1'b0);
        send_bin(25'd5, 1'b1);
        // cdf above pixel_count: saturate to full scale
        send_bin(25'd10, 1'b0);
        send_bin(25'd200, 1'b1);
        // no nonzero bin at all
        send_bin(25'd0, 1'b0);
        send_bin(25'd0, 1'b1);
        drain();
        set_pixel_count(COUNT_MAX);
        // cumulative sum overflows and saturates
        send_bin(25'd1, 1'b0);
        send_bin(COUNT_MAX, 1'b0);
        send_bin(COUNT_MAX, 1'b1);
        drain();
        set_pixel_count(25'd0);
        send_bin(25'd0, 1'b0);
        send_bin(25'd7, 1'b1);

        target = bins_sent + RANDOM_BINS;
        phase  = 0;
        while (bins_sent < target) begin
            case (phase % 8)
                0:       pc = 25'd1;
                1:       pc = 25'd16777216;
                2:       pc = COUNT_MAX;
                3:       pc = 25'd0;
                4:       pc = CNT_W'($urandom_range(2, 300));
                5:       pc = CNT_W'($urandom);
                default: pc = CNT_W'($urandom_range(256, 65536));
            endcase
            drain();
            set_pixel_count(pc);
            calm = (phase == 4);
            // fill the block while the output side is held off
            if (phase == 1) hold_request = 1'b1;
            phase_end = bins_sent + $urandom_range(120, 200);
            while (bins_sent < phase_end && bins_sent < target) send_frame(pc);
            calm = 1'b0;
            phase++;
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.entries_checked < bins_sent && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        // catch stray beats after the last expected one
        repeat (24) @(posedge i_clk);
        if (sb.pending.size() != 0 || sb.entries_checked < bins_sent) begin
            $error("%0d table entries never came out", bins_sent - sb.entries_checked);
            sb.mismatches++;
        end

        $display("checked %0d entries from %0d bin beats in %0d tables, %0d pixel_count values",
                 sb.entries_checked, bins_sent, tables_sent, settings);
        $display("%0d degenerate entries, %0d at full scale, %0d mismatches",
                 sb.degenerate_entries, sb.saturated_entries, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hel_pkg.sv
rtl/hel_front.sv
rtl/hel_queue.sv
rtl/hel_back.sv
rtl/histogram_equalization_lut.sv
tb/sv/histogram_equalization_lut_tb.sv
